>>> rtl/stbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbm_pkg: shared types and constants
// Widths, command and status codes, and the request and result structs of the
// packed triangular byte matrix.
// ----------------------------------------------------------------------------
package stbm_pkg;

  localparam int MaxSize     = 64;
  localparam int WindowBytes = 1024;
  localparam int SizeMax     = (MaxSize < WindowBytes) ? MaxSize : WindowBytes;

  localparam int RowW  = $clog2(MaxSize);
  localparam int SizeW = $clog2(MaxSize + 1);
  localparam int OffW  = $clog2(WindowBytes + 1);
  localparam int AddrW = $clog2(WindowBytes);
  localparam int SumW  = OffW + 1;
  localparam int ByteW = 8;
  localparam int CmdW  = 2;
  localparam int StatW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_RESTART = 2'd0,
    CMD_SLIDE   = 2'd1,
    CMD_SET     = 2'd2,
    CMD_GET     = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK  = 2'd0,
    ST_ROW = 2'd1,
    ST_COL = 2'd2,
    ST_END = 2'd3
  } status_e;

  typedef struct packed {
    logic            we;
    logic [RowW-1:0] addr;
    logic [OffW-1:0] wdata;
  } tab_req_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] wdata;
  } store_req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [ByteW-1:0] read_value;
    logic [RowW-1:0]  first_row;
    logic [RowW-1:0]  last_row;
    logic [SizeW-1:0] rows_held;
  } result_t;

endpackage

>>> rtl/stbm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbm_if: command and result channels
// Valid/ready channels carrying one command word in and one result word out.
// ----------------------------------------------------------------------------
interface stbm_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [stbm_pkg::RowW-1:0]  row;
  logic [stbm_pkg::RowW-1:0]  col;
  logic [stbm_pkg::ByteW-1:0] write_value;

  modport source (output valid, command, row, col, write_value, input ready);
  modport sink   (input valid, command, row, col, write_value, output ready);
endinterface

interface stbm_out_if;
  logic                        valid;
  logic                        ready;
  logic [stbm_pkg::StatW-1:0]  status;
  logic [stbm_pkg::ByteW-1:0]  read_value;
  logic [stbm_pkg::RowW-1:0]   first_row;
  logic [stbm_pkg::RowW-1:0]   last_row;
  logic [stbm_pkg::SizeW-1:0]  rows_held;

  modport source (output valid, status, read_value, first_row, last_row, rows_held,
                  input ready);
  modport sink   (input valid, status, read_value, first_row, last_row, rows_held,
                  output ready);
endinterface

>>> rtl/stbm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbm_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module stbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/stbm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbm_seq: command sequencer
// Holds the window and size registers, rebuilds the row offset table one row
// a cycle, and resolves set/get addresses through one shared adder.
// ----------------------------------------------------------------------------
module stbm_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [stbm_pkg::SizeW-1:0] cfg_wdata_i,
  stbm_in_if.sink                    in_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output stbm_pkg::result_t          res_o,
  output stbm_pkg::tab_req_t         tab_req_o,
  input  logic [stbm_pkg::OffW-1:0]  tab_rdata_i,
  output stbm_pkg::store_req_t       store_req_o,
  input  logic [stbm_pkg::ByteW-1:0] store_rdata_i
);
  import stbm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD,
    S_LOOKUP,
    S_FETCH,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [SizeW-1:0] size_q;
  logic             valid_q;
  logic [RowW-1:0]  first_q;
  logic [RowW-1:0]  last_q;
  logic [SizeW-1:0] rows_q;
  cmd_e             cmd_q;
  logic [RowW-1:0]  row_q;
  logic [RowW-1:0]  col_q;
  logic [ByteW-1:0] wval_q;
  logic [SizeW-1:0] r_q;
  logic [OffW-1:0]  sum_q;
  status_e          status_q;
  logic [ByteW-1:0] rdval_q;

  logic             accept;
  logic             row_ok;
  logic             col_ok;
  logic [SizeW-1:0] len;
  logic [RowW-1:0]  diff;
  logic [SumW-1:0]  op_a;
  logic [SumW-1:0]  op_b;
  logic [SumW-1:0]  sum_w;
  logic             fits;
  logic             build_more;
  logic [SizeW-1:0] size_d;
  logic [SizeW-1:0] next_start;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign row_ok = valid_q && (in_i.row >= first_q) && (in_i.row <= last_q);
  assign col_ok = (in_i.col > in_i.row) && ({1'b0, in_i.col} < size_q);

  assign len  = size_q - r_q - SizeW'(1);
  assign diff = col_q - row_q - RowW'(1);

  // shared adder: running row sum while building, byte address on lookup
  always_comb begin
    if (state_q == S_BUILD) begin
      op_a = {1'b0, sum_q};
      op_b = {{(SumW-SizeW){1'b0}}, len};
    end else begin
      op_a = {1'b0, tab_rdata_i};
      op_b = {{(SumW-RowW){1'b0}}, diff};
    end
  end
  assign sum_w = op_a + op_b;

  assign fits       = (sum_w <= SumW'(WindowBytes));
  assign build_more = (r_q < size_q) && fits;
  assign next_start = {1'b0, last_q} + SizeW'(1);

  always_comb begin
    size_d = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      size_d = SizeW'(1);
    end else if (cfg_wdata_i > SizeW'(SizeMax)) begin
      size_d = SizeW'(SizeMax);
    end
  end

  always_comb begin
    tab_req_o.we    = (state_q == S_BUILD) && build_more;
    tab_req_o.wdata = sum_q;
    if (state_q == S_BUILD) begin
      tab_req_o.addr = r_q[RowW-1:0] - first_q;
    end else begin
      tab_req_o.addr = in_i.row - first_q;
    end
    store_req_o.we    = (state_q == S_LOOKUP) && (cmd_q == CMD_SET)
                        && (sum_w < SumW'(WindowBytes));
    store_req_o.addr  = sum_w[AddrW-1:0];
    store_req_o.wdata = wval_q;
  end

  assign res_valid_o      = (state_q == S_DONE);
  assign res_o.status     = status_q;
  assign res_o.read_value = rdval_q;
  assign res_o.first_row  = first_q;
  assign res_o.last_row   = last_q;
  assign res_o.rows_held  = rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      size_q   <= SizeW'(SizeMax);
      valid_q  <= 1'b0;
      first_q  <= '0;
      last_q   <= '0;
      rows_q   <= '0;
      cmd_q    <= CMD_RESTART;
      row_q    <= '0;
      col_q    <= '0;
      wval_q   <= '0;
      r_q      <= '0;
      sum_q    <= '0;
      status_q <= ST_OK;
      rdval_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            // new size closes the window
            size_q  <= size_d;
            valid_q <= 1'b0;
            first_q <= '0;
            last_q  <= '0;
            rows_q  <= '0;
          end
          if (accept) begin
            cmd_q    <= cmd_e'(in_i.command);
            row_q    <= in_i.row;
            col_q    <= in_i.col;
            wval_q   <= in_i.write_value;
            rdval_q  <= '0;
            status_q <= ST_OK;
            sum_q    <= '0;
            unique case (cmd_e'(in_i.command))
              CMD_RESTART: begin
                r_q     <= '0;
                first_q <= '0;
                last_q  <= '0;
                state_q <= S_BUILD;
              end
              CMD_SLIDE: begin
                if (!valid_q) begin
                  status_q <= ST_ROW;
                  state_q  <= S_DONE;
                end else if (next_start >= size_q) begin
                  status_q <= ST_END;
                  state_q  <= S_DONE;
                end else begin
                  r_q     <= next_start;
                  first_q <= next_start[RowW-1:0];
                  last_q  <= next_start[RowW-1:0];
                  state_q <= S_BUILD;
                end
              end
              CMD_SET, CMD_GET: begin
                if (!row_ok) begin
                  status_q <= ST_ROW;
                  state_q  <= S_DONE;
                end else if (!col_ok) begin
                  status_q <= ST_COL;
                  state_q  <= S_DONE;
                end else begin
                  state_q <= S_LOOKUP;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_BUILD: begin
          if (build_more) begin
            sum_q  <= sum_w[OffW-1:0];
            last_q <= r_q[RowW-1:0];
            r_q    <= r_q + SizeW'(1);
          end else begin
            rows_q  <= {1'b0, last_q} - {1'b0, first_q} + SizeW'(1);
            valid_q <= 1'b1;
            state_q <= S_DONE;
          end
        end
        S_LOOKUP: begin
          if (sum_w >= SumW'(WindowBytes)) begin
            status_q <= ST_COL;
            state_q  <= S_DONE;
          end else if (cmd_q == CMD_SET) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          rdval_q <= store_rdata_i;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/sliding_triangular_byte_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_triangular_byte_matrix: windowed packed upper-triangular byte store
// Keeps a run of packed rows of a strictly upper-triangular byte matrix in a
// byte RAM, with a row offset RAM rebuilt on restart and slide.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          word
//  in_i      in   valid / ready      command, row, col, write_value
//  out_o     out  valid / ready      status, read_value, first_row, last_row,
//                                    rows_held
//  cfg       in   cfg_we_i           cfg_wdata_i (diagonal size)
//
// set passes through LOOKUP and get through LOOKUP and FETCH before DONE; an
// error or end-of-matrix answer found on accept goes straight to DONE. restart
// and slide build one row per cycle through the offset table write port and the
// shared adder; a window holds at most 45 rows.
// in_i.ready is high only while the sequencer is idle; one result waits in the
// output register, so a new word is accepted while out_o is stalled.
// reset closes the window; no clearing pass, the RAMs are never cleared.
// ----------------------------------------------------------------------------
module sliding_triangular_byte_matrix (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [stbm_pkg::SizeW-1:0] cfg_wdata_i,
  stbm_in_if.sink                    in_i,
  stbm_out_if.source                 out_o
);
  import stbm_pkg::*;

  logic       res_valid;
  logic       res_ready;
  result_t    res;
  tab_req_t   tab_req;
  store_req_t store_req;
  logic [OffW-1:0]  tab_rdata;
  logic [ByteW-1:0] store_rdata;

  logic    out_valid_q;
  result_t out_q;

  stbm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_i          (in_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .tab_req_o     (tab_req),
    .tab_rdata_i   (tab_rdata),
    .store_req_o   (store_req),
    .store_rdata_i (store_rdata)
  );

  stbm_ram #(
    .Width (OffW),
    .Depth (MaxSize)
  ) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_req.we),
    .addr_i  (tab_req.addr),
    .wdata_i (tab_req.wdata),
    .rdata_o (tab_rdata)
  );

  stbm_ram #(
    .Width (ByteW),
    .Depth (WindowBytes)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (store_req.we),
    .addr_i  (store_req.addr),
    .wdata_i (store_req.wdata),
    .rdata_o (store_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_q.status;
  assign out_o.read_value = out_q.read_value;
  assign out_o.first_row  = out_q.first_row;
  assign out_o.last_row   = out_q.last_row;
  assign out_o.rows_held  = out_q.rows_held;

  // a finished word always lands in the output register
  a_res_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_valid_q)
    else $error("result not loaded into output register");

  // the sequencer is busy in the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted twice in a row");

  // an open window reports consistent bounds
  a_rows_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.rows_held != '0) |->
      (out_q.rows_held == ({1'b0, out_q.last_row} - {1'b0, out_q.first_row}
                           + SizeW'(1))))
    else $error("rows_held does not match window bounds");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sliding triangular byte matrix
// Drives command words through the valid/ready input channel, predicts every
// result word with a behavioral model of the packed row window, and checks
// each result word field by field in order. Directed tests cover the closed
// window, byte access, sliding to the end and the size register; a random
// test then runs mostly well-formed traffic over a series of matrix sizes
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module testbench;
  import stbm_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 80;
  localparam int RandomItems  = 750;
  localparam int MaxReports   = 10;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [SizeW-1:0] cfg_wdata;

  stbm_in_if  in_ch ();
  stbm_out_if out_ch ();

  sliding_triangular_byte_matrix i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // window model
  int          diag_n;
  int          span_first;
  int          span_last;
  int          span_rows;
  bit          span_open;
  int          row_base [MaxSize];
  logic [7:0]  cell_byte [WindowBytes];
  bit          cell_set [WindowBytes];
  logic [2*RowW-1:0] set_cells [$];

  result_t pending_answers [$];
  int      fail_count;
  int      cycle_count;
  bit      tx_gaps_on;
  bit      rx_stall_on;
  int      stall_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void close_span();
    span_open  = 1'b0;
    span_first = 0;
    span_last  = 0;
    span_rows  = 0;
    cell_set   = '{default: 1'b0};
    set_cells.delete();
  endfunction

  // pack rows from start while their lengths still fit the byte window
  function automatic void open_span(input int start);
    int r;
    int sum;
    bit fits;
    r = start;
    sum = 0;
    fits = 1'b1;
    span_first = start;
    span_last  = start;
    while (fits && r < diag_n && r - start < MaxSize) begin
      if (sum + (diag_n - r - 1) > WindowBytes) begin
        fits = 1'b0;
      end else begin
        row_base[r - start] = sum;
        sum += diag_n - r - 1;
        span_last = r;
        r++;
      end
    end
    span_rows = span_last - span_first + 1;
    span_open = 1'b1;
    cell_set  = '{default: 1'b0};
    set_cells.delete();
  endfunction

  function automatic void apply_size(input int v);
    diag_n = (v < 1) ? 1 : (v > SizeMax) ? SizeMax : v;
    close_span();
  endfunction

  // row is checked before column
  function automatic status_e find_cell(input int i, input int j, output int addr);
    addr = 0;
    if (!span_open || i < span_first || i > span_last) return ST_ROW;
    if (j <= i || j >= diag_n) return ST_COL;
    addr = row_base[i - span_first] + j - i - 1;
    if (addr >= WindowBytes) return ST_COL;
    return ST_OK;
  endfunction

  function automatic result_t matrix_answer(input cmd_e c, input int i, input int j,
                                            input logic [7:0] wv);
    status_e    st;
    int         addr;
    logic [7:0] rd;
    result_t    r;
    st = ST_OK;
    rd = '0;
    case (c)
      CMD_RESTART: open_span(0);
      CMD_SLIDE: begin
        if (!span_open) st = ST_ROW;
        else if (span_last + 1 >= diag_n) st = ST_END;
        else open_span(span_last + 1);
      end
      CMD_SET: begin
        st = find_cell(i, j, addr);
        if (st == ST_OK) begin
          cell_byte[addr] = wv;
          if (!cell_set[addr]) set_cells.push_back({RowW'(i), RowW'(j)});
          cell_set[addr] = 1'b1;
        end
      end
      default: begin
        st = find_cell(i, j, addr);
        if (st == ST_OK && cell_set[addr]) rd = cell_byte[addr];
      end
    endcase
    r.status     = st;
    r.read_value = rd;
    r.first_row  = RowW'(span_first);
    r.last_row   = RowW'(span_last);
    r.rows_held  = SizeW'(span_rows);
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (!tx_gaps_on) return 0;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic int rnd_row();
    return $urandom_range(MaxSize - 1);
  endfunction

  // returns right after the edge that accepted the word; valid stays high
  task automatic send_word(input cmd_e c, input int row, input int col, input int wv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= c;
    in_ch.row         <= RowW'(row);
    in_ch.col         <= RowW'(col);
    in_ch.write_value <= ByteW'(wv);
    do @(posedge clk); while (!in_ch.ready);
    pending_answers.push_back(matrix_answer(c, row, col, ByteW'(wv)));
  endtask

  task automatic drain_answers();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic write_size(input int v);
    drain_answers();
    cfg_we    <= 1'b1;
    cfg_wdata <= SizeW'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    apply_size(v);
  endtask

  task automatic note_failure(input string what, input result_t want, input result_t got);
    fail_count++;
    if (fail_count <= MaxReports) begin
      $display("%0t: %s: expected st=%0d rd=%02h first=%0d last=%0d rows=%0d", $realtime,
               what, want.status, want.read_value, want.first_row, want.last_row,
               want.rows_held);
      $display("%0t: %s: actual   st=%0d rd=%02h first=%0d last=%0d rows=%0d", $realtime,
               what, got.status, got.read_value, got.first_row, got.last_row,
               got.rows_held);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      got.status     = out_ch.status;
      got.read_value = out_ch.read_value;
      got.first_row  = out_ch.first_row;
      got.last_row   = out_ch.last_row;
      got.rows_held  = out_ch.rows_held;
      if (pending_answers.size() == 0) begin
        note_failure("unexpected result word", '0, got);
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status || got.read_value !== want.read_value ||
            got.first_row !== want.first_row || got.last_row !== want.last_row ||
            got.rows_held !== want.rows_held) begin
          note_failure("result mismatch", want, got);
        end
      end
    end
  end

  // output stalls: mostly short, a few long
  initial begin
    out_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (rx_stall_on) begin
          case ($urandom_range(99)) inside
            [0:4]:   stall_left = $urandom_range(40, 10);
            [5:24]:  stall_left = $urandom_range(3, 1);
            default: stall_left = 0;
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic test_closed_window();
    send_word(CMD_SLIDE, 0, 0, 8'h00);
    send_word(CMD_SET, 3, 9, 8'hA5);
    send_word(CMD_GET, 0, 1, 8'h5A);
  endtask

  task automatic test_byte_access();
    send_word(CMD_RESTART, 63, 63, 8'hFF);
    send_word(CMD_SET, 0, 1, 8'hFF);
    send_word(CMD_SET, 0, 63, 8'h00);
    send_word(CMD_SET, 1, 2, 8'h5A);
    send_word(CMD_GET, 0, 1, 8'h00);
    send_word(CMD_GET, 0, 63, 8'hFF);
    send_word(CMD_GET, 1, 2, 8'h00);
    // row outside the window wins over a bad column
    send_word(CMD_SET, 63, 0, 8'h11);
    send_word(CMD_SET, 5, 5, 8'h22);
    send_word(CMD_GET, 7, 3, 8'h00);
  endtask

  task automatic test_slide_to_end();
    while (span_open && span_last + 1 < diag_n) begin
      send_word(CMD_SLIDE, rnd_row(), rnd_row(), $urandom_range(255));
    end
    send_word(CMD_SET, 62, 63, 8'hC3);
    send_word(CMD_GET, 62, 63, 8'h3C);
    send_word(CMD_SET, 63, 63, 8'h01);
    send_word(CMD_GET, 0, 1, 8'h00);
    send_word(CMD_SLIDE, 0, 0, 8'h00);
    send_word(CMD_SLIDE, 63, 63, 8'hFF);
  endtask

  task automatic test_size_register();
    write_size(0);
    send_word(CMD_SET, 0, 1, 8'h77);
    send_word(CMD_RESTART, 0, 0, 8'h00);
    send_word(CMD_SET, 0, 1, 8'h77);
    send_word(CMD_SLIDE, 0, 0, 8'h00);
    write_size(2);
    send_word(CMD_RESTART, 0, 0, 8'h00);
    send_word(CMD_SET, 0, 1, 8'h96);
    send_word(CMD_GET, 0, 1, 8'h00);
    write_size(127);
    send_word(CMD_RESTART, 0, 0, 8'h00);
  endtask

  task automatic random_word();
    int p;
    int i;
    int j;
    int addr;
    logic [2*RowW-1:0] slot;
    p = $urandom_range(99);
    if (p < 3 || (!span_open && p < 70)) begin
      send_word(CMD_RESTART, rnd_row(), rnd_row(), $urandom_range(255));
    end else if (p < 9) begin
      send_word(CMD_SLIDE, rnd_row(), rnd_row(), $urandom_range(255));
    end else if (p >= 52 && p < 85 && set_cells.size() != 0) begin
      slot = set_cells[$urandom_range(set_cells.size() - 1)];
      send_word(CMD_GET, int'(slot[2*RowW-1:RowW]), int'(slot[RowW-1:0]),
                $urandom_range(255));
    end else if (p < 85) begin
      i = $urandom_range(span_last, span_first);
      j = (i + 1 < diag_n) ? $urandom_range(diag_n - 1, i + 1) : rnd_row();
      send_word(CMD_SET, i, j, $urandom_range(255));
    end else begin
      // noise: any row and column, but never a read of a byte not yet set
      i = rnd_row();
      j = rnd_row();
      if (p < 93 || (find_cell(i, j, addr) == ST_OK && !cell_set[addr])) begin
        send_word(CMD_SET, i, j, $urandom_range(255));
      end else begin
        send_word(CMD_GET, i, j, $urandom_range(255));
      end
    end
  endtask

  task automatic test_random_traffic();
    int sizes [9];
    int per_phase;
    sizes = '{64, 0, 127, 2, 45, 46, 1, 30, 0};
    sizes[8] = $urandom_range(127);
    per_phase = RandomItems / 9;
    for (int ph = 0; ph < 9; ph++) begin
      write_size(sizes[ph]);
      tx_gaps_on  = (ph % 3 != 0);
      rx_stall_on = (ph % 4 != 1);
      for (int n = 0; n < per_phase; n++) begin
        if (n == per_phase / 2) drain_answers();
        random_word();
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_RESTART;
    in_ch.row         = '0;
    in_ch.col         = '0;
    in_ch.write_value = '0;
    fail_count        = 0;
    tx_gaps_on        = 1'b0;
    rx_stall_on       = 1'b0;
    diag_n            = 64;
    close_span();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_closed_window();
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    test_byte_access();
    test_slide_to_end();
    test_size_register();
    test_random_traffic();

    drain_answers();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
